// ----- design/wmst_pkg.sv -----
package wmst_pkg;

  localparam int unsigned HistDepthDefault = 150;
  localparam logic [31:0] WindowResetValue = 32'd5000000;
  localparam int unsigned TimeW = 63;
  localparam int unsigned ValW = 32;
  localparam int unsigned OutW = 36;
  localparam int unsigned CountW = 8;

  // register byte addresses
  localparam logic [1:0] RegWindow = 2'd0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAP,
    ST_WRITE,
    ST_RD,
    ST_ACC,
    ST_MUL,
    ST_MEAN,
    ST_VAR,
    ST_SQRT,
    ST_SDIV,
    ST_OUT
  } state_t;

endpackage

// ----- design/windowed_mean_stddev_tracker_core.sv -----
// Sliding time-window mean / population standard deviation tracker. Each input
// beat is a signed sample with a timestamp; the block keeps the last
// HISTORY_DEPTH samples in a ring, empties the ring when the newest stored
// sample is more than the window older than the new one, and returns the mean
// and standard deviation (4 fraction bits, truncated) and the count of stored
// samples inside the window. One item is processed at a time: the next beat
// is taken only once the previous result has moved to the output register.
// Each beat is written to the ring, then each stored sample is read and its
// 32x32 square formed, then come a serial 72-bit multiply for n*S2 and S1^2,
// a serial unsigned divide of |S1| for the mean, whose sign is put back,
// a bit-serial square root and a serial divide by n. A stalled output register
// holds the block until the previous result is taken. A finished result waits
// in the output register while the next beat is already accepted.
module windowed_mean_stddev_tracker_core #(
  parameter int unsigned HISTORY_DEPTH = wmst_pkg::HistDepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_sample_delta,
  input  logic [62:0] in_sample_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [35:0] out_window_mean,
  output logic [35:0] out_window_stddev,
  output logic [7:0]  out_window_count,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned PtrW = $clog2(HISTORY_DEPTH);
  localparam int unsigned NW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned S1W = 32 + NW;
  localparam int unsigned S2W = 64 + NW;
  // n*S2 and S1^2 share a width; the radicand needs 8 more bits for the 256 scale
  localparam int unsigned DW = S2W + NW;
  localparam int unsigned AW = DW + 8 + (DW % 2);
  localparam int unsigned RW = AW / 2;
  localparam int unsigned MNW = S1W + 4;
  localparam int unsigned MCW = $clog2(DW + 1);
  localparam int unsigned RCW = $clog2(RW + 1);

  // config register
  logic [31:0] win_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= wmst_pkg::WindowResetValue;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr == wmst_pkg::RegWindow) begin
      win_r <= cfg_pwdata;
    end
  end
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == wmst_pkg::RegWindow) ? win_r : 32'd0;

  // history memories
  logic signed [31:0] val_mem [HISTORY_DEPTH];
  logic [62:0]        tim_mem [HISTORY_DEPTH];
  logic               mem_we;
  logic [PtrW-1:0]    mem_wa, mem_ra;
  logic signed [31:0] val_rd_r;
  logic [62:0]        tim_rd_r;

  wmst_pkg::state_t st_r, st_nxt;
  logic signed [31:0] x_r;
  logic [62:0]        now_r, cut_r;
  logic [PtrW-1:0]    wp_r, wp_nxt;
  logic [NW-1:0]      cnt_r, cnt_nxt;
  logic [NW-1:0]      idx_r, n_r;
  logic signed [S1W-1:0] s1_r;
  logic [S2W-1:0]     s2_r;
  logic [63:0]        sq_r;
  logic               inwin_r;
  logic [DW-1:0]      ns2_r, s1sq_r, mcand_r;
  logic [S2W-1:0]     mplA_r;
  logic [S1W-1:0]     mplB_r;
  logic [MCW-1:0]     mc_r;
  logic [AW-1:0]      rad_r;
  logic [RW+1:0]      rrem_r;
  logic [RW-1:0]      root_r;
  logic [RCW-1:0]     rc_r;
  logic signed [35:0] mean_r;
  logic [35:0]        sd_r;
  logic [7:0]         cntout_r;
  logic               ovalid_r;
  logic [S1W-1:0]     s1mag;
  logic               mean_neg_r;
  logic               dv_start;
  logic [MNW-1:0]     dv_num;
  logic               dv_done;
  logic [MNW-1:0]     dv_quo;
  logic               sd_start;
  logic               sd_done;
  logic [RW-1:0]      sd_quo;
  logic [63:0]        last_lim;
  logic [63:0]        sqm;
  logic [31:0]        vmag;
  logic [RW+1:0]      rtrial;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      val_mem[mem_wa] <= x_r;
      tim_mem[mem_wa] <= now_r;
    end
    val_rd_r <= val_mem[mem_ra];
    tim_rd_r <= tim_mem[mem_ra];
  end

  assign in_stall = (st_r != wmst_pkg::ST_IDLE);
  assign mem_we = (st_r == wmst_pkg::ST_WRITE);
  assign mem_wa = wp_r;
  // newest entry is read while idle so the gap check sees it
  assign mem_ra = (st_r == wmst_pkg::ST_IDLE || st_r == wmst_pkg::ST_GAP) ?
                  ((wp_r == '0) ? PtrW'(HISTORY_DEPTH - 1) : wp_r - 1'b1) :
                  idx_r[PtrW-1:0];

  assign s1mag = s1_r[S1W-1] ? S1W'(-s1_r) : S1W'(s1_r);
  assign vmag = val_rd_r[31] ? 32'(-val_rd_r) : 32'(val_rd_r);
  assign sqm = vmag * vmag;
  assign last_lim = {1'b0, tim_rd_r} + {32'd0, win_r};
  assign dv_num = {s1mag, 4'd0};
  assign rtrial = {rrem_r[RW-1:0], rad_r[AW-1:AW-2]} - {root_r, 2'b01};

  wmst_serial_div #(.NumW(MNW), .DenW(NW)) u_mdiv (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num), .den(n_r),
    .done(dv_done), .quo(dv_quo));

  wmst_serial_div #(.NumW(RW), .DenW(NW)) u_sdiv (
    .clk(clk), .rst_n(rst_n), .start(sd_start), .num(root_r), .den(n_r),
    .done(sd_done), .quo(sd_quo));

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      wmst_pkg::ST_IDLE:  if (in_valid) st_nxt = wmst_pkg::ST_GAP;
      wmst_pkg::ST_GAP:   st_nxt = wmst_pkg::ST_WRITE;
      wmst_pkg::ST_WRITE: st_nxt = wmst_pkg::ST_RD;
      wmst_pkg::ST_RD:    st_nxt = wmst_pkg::ST_ACC;
      wmst_pkg::ST_ACC: begin
        if (idx_r == cnt_r) st_nxt = wmst_pkg::ST_MUL;
        else st_nxt = wmst_pkg::ST_RD;
      end
      wmst_pkg::ST_MUL:   if (mc_r == '0) st_nxt = wmst_pkg::ST_MEAN;
      wmst_pkg::ST_MEAN:  if (dv_done) st_nxt = wmst_pkg::ST_VAR;
      wmst_pkg::ST_VAR:   st_nxt = wmst_pkg::ST_SQRT;
      wmst_pkg::ST_SQRT:  if (rc_r == '0) st_nxt = wmst_pkg::ST_SDIV;
      wmst_pkg::ST_SDIV:  if (sd_done) st_nxt = wmst_pkg::ST_OUT;
      wmst_pkg::ST_OUT:   if (!ovalid_r || !out_stall) st_nxt = wmst_pkg::ST_IDLE;
      default:            st_nxt = wmst_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    wp_nxt = wp_r;
    cnt_nxt = cnt_r;
    dv_start = 1'b0;
    sd_start = 1'b0;
    case (st_r)
      wmst_pkg::ST_GAP: begin
        if (cnt_r != '0 && {1'b0, now_r} > last_lim) begin
          wp_nxt = '0;
          cnt_nxt = '0;
        end
      end
      wmst_pkg::ST_WRITE: begin
        wp_nxt = (wp_r == PtrW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + 1'b1;
        if (cnt_r != NW'(HISTORY_DEPTH)) cnt_nxt = cnt_r + 1'b1;
      end
      wmst_pkg::ST_MUL: dv_start = (mc_r == '0);
      wmst_pkg::ST_SQRT: sd_start = (rc_r == '0);
      default: ;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      wmst_pkg::ST_IDLE: begin
        x_r <= in_sample_delta;
        now_r <= in_sample_time;
        cut_r <= (in_sample_time > {31'd0, win_r}) ?
                 in_sample_time - {31'd0, win_r} : '0;
      end
      wmst_pkg::ST_WRITE: begin
        idx_r <= '0;
        s1_r <= '0;
        s2_r <= '0;
        n_r <= '0;
        sq_r <= '0;
        inwin_r <= 1'b0;
      end
      wmst_pkg::ST_RD: begin
        // fold the previous sample, compare this one
        if (inwin_r) s2_r <= s2_r + S2W'(sq_r);
        idx_r <= idx_r + 1'b1;
      end
      wmst_pkg::ST_ACC: begin
        inwin_r <= (tim_rd_r >= cut_r);
        sq_r <= sqm;
        if (tim_rd_r >= cut_r) begin
          s1_r <= s1_r + S1W'(val_rd_r);
          n_r <= n_r + 1'b1;
        end
        if (idx_r == cnt_r) begin
          // start serial multiplies: n*S2 and |S1|^2
          mc_r <= MCW'(S2W + 1);
          ns2_r <= '0;
          s1sq_r <= '0;
          mcand_r <= '0;
        end
      end
      wmst_pkg::ST_MUL: begin
        if (mc_r == MCW'(S2W + 1)) begin
          if (inwin_r) begin
            mplA_r <= s2_r + S2W'(sq_r);
          end else begin
            mplA_r <= s2_r;
          end
          mplB_r <= s1mag;
          mcand_r <= DW'(s1mag);
          mean_neg_r <= s1_r[S1W-1];
          mc_r <= mc_r - 1'b1;
        end else if (mc_r != '0) begin
          // one multiplier bit per cycle, msb first
          ns2_r <= (ns2_r << 1) + (mplA_r[S2W-1] ? DW'(n_r) : '0);
          s1sq_r <= (s1sq_r << 1) + (mplB_r[S1W-1] && (mc_r <= MCW'(S1W)) ?
                    mcand_r : '0);
          mplA_r <= mplA_r << 1;
          if (mc_r <= MCW'(S1W)) mplB_r <= mplB_r << 1;
          mc_r <= mc_r - 1'b1;
        end
      end
      wmst_pkg::ST_MEAN: begin
        if (dv_done) begin
          mean_r <= mean_neg_r ? 36'(-dv_quo) : 36'(dv_quo);
        end
      end
      wmst_pkg::ST_VAR: begin
        rad_r <= AW'(ns2_r - s1sq_r) << 8;
        rrem_r <= '0;
        root_r <= '0;
        rc_r <= RCW'(RW);
      end
      wmst_pkg::ST_SQRT: begin
        // one root bit per cycle
        if (rc_r != '0) begin
          if (!rtrial[RW+1]) begin
            rrem_r <= rtrial;
            root_r <= {root_r[RW-2:0], 1'b1};
          end else begin
            rrem_r <= {rrem_r[RW-1:0], rad_r[AW-1:AW-2]};
            root_r <= {root_r[RW-2:0], 1'b0};
          end
          rad_r <= rad_r << 2;
          rc_r <= rc_r - 1'b1;
        end
      end
      wmst_pkg::ST_SDIV: if (sd_done) sd_r <= 36'(sd_quo);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (st_r == wmst_pkg::ST_OUT && (!ovalid_r || !out_stall)) begin
      out_window_mean <= mean_r;
      out_window_stddev <= sd_r;
      out_window_count <= (n_r > NW'(255)) ? 8'd255 : 8'(n_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= wmst_pkg::ST_IDLE;
      wp_r <= '0;
      cnt_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      wp_r <= wp_nxt;
      cnt_r <= cnt_nxt;
      if (st_r == wmst_pkg::ST_OUT && (!ovalid_r || !out_stall)) ovalid_r <= 1'b1;
      else if (!out_stall) ovalid_r <= 1'b0;
    end
  end

  assign out_valid = ovalid_r;

endmodule

// ----- design/wmst_serial_div.sv -----
// bit-serial unsigned restoring divider, one quotient bit per cycle
module wmst_serial_div #(
  parameter int unsigned NumW = 100,
  parameter int unsigned DenW = 11
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic            done,
  output logic [NumW-1:0] quo
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_r, quo_nxt;
  logic [DenW:0]   rem_r, rem_nxt;
  logic [DenW-1:0] den_r, den_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [DenW:0]   trial;

  assign trial = {rem_r[DenW-1:0], quo_r[NumW-1]};

  // one shift-subtract step per cycle
  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = CntW'(NumW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[NumW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[NumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo = quo_r;

endmodule

// ----- tb/tb_windowed_mean_stddev_tracker_core.sv -----
`timescale 1ns / 100ps

// running window statistics expected for each accepted sample
class stats_scoreboard;
  localparam int unsigned Depth = wmst_pkg::HistDepthDefault;
  logic signed [31:0] vals [Depth];
  logic [63:0]        times [Depth];
  int unsigned        wr_ptr;
  int unsigned        fill;
  logic [31:0]        window_us;
  logic [35:0]        exp_mean [$];
  logic [35:0]        exp_sd [$];
  logic [7:0]         exp_cnt [$];
  int                 errors;
  int                 checked;

  function new();
    wr_ptr = 0;
    fill = 0;
    window_us = 32'd5000000;
    errors = 0;
    checked = 0;
  endfunction

  // integer square root of a 96-bit value
  function automatic logic [47:0] isqrt(logic [95:0] a);
    logic [47:0] r;
    logic [47:0] t;
    r = '0;
    for (int b = 47; b >= 0; b--) begin
      t = r | (48'd1 << b);
      if ({48'd0, t} * {48'd0, t} <= a) r = t;
    end
    return r;
  endfunction

  // note an accepted sample and compute its statistics
  function void note_sample(logic [31:0] delta, logic [62:0] now_t);
    int unsigned last;
    logic [63:0] now;
    logic [63:0] cutoff;
    logic signed [63:0] s1;
    logic [95:0] s2;
    logic [95:0] d;
    logic [63:0] mag;
    logic signed [63:0] mean;
    logic [95:0] root;
    int unsigned n;
    now = {1'b0, now_t};
    if (fill > 0) begin
      last = (wr_ptr + Depth - 1) % Depth;
      if (now > times[last] + {32'd0, window_us}) begin
        fill = 0;
        wr_ptr = 0;
      end
    end
    vals[wr_ptr] = delta;
    times[wr_ptr] = now;
    wr_ptr = (wr_ptr + 1) % Depth;
    if (fill < Depth) fill++;
    cutoff = (now > {32'd0, window_us}) ? now - {32'd0, window_us} : 64'd0;
    s1 = 0;
    s2 = 0;
    n = 0;
    for (int i = 0; i < fill; i++) begin
      if (times[i] >= cutoff) begin
        s1 += 64'(vals[i]);
        s2 += 96'(64'(vals[i]) * 64'(vals[i]));
        n++;
      end
    end
    mean = (s1 * 16) / $signed(64'(n));
    mag = (s1 < 0) ? -s1 : s1;
    d = s2 * 96'(n) - 96'(mag) * 96'(mag);
    root = 96'(isqrt(d << 8)) / 96'(n);
    exp_mean.push_back(mean[35:0]);
    exp_sd.push_back(root[35:0]);
    exp_cnt.push_back((n > 255) ? 8'd255 : 8'(n));
  endfunction

  // compare one result beat against the oldest expectation
  function void check_result(logic [35:0] mean, logic [35:0] sd, logic [7:0] cnt);
    logic [35:0] em;
    logic [35:0] es;
    logic [7:0]  ec;
    if (exp_mean.size() == 0) begin
      $error("result beat with no sample pending");
      errors++;
      return;
    end
    em = exp_mean.pop_front();
    es = exp_sd.pop_front();
    ec = exp_cnt.pop_front();
    checked++;
    if (mean !== em) begin
      $error("window_mean expected %0h actual %0h", em, mean);
      errors++;
    end
    if (sd !== es) begin
      $error("window_stddev expected %0h actual %0h", es, sd);
      errors++;
    end
    if (cnt !== ec) begin
      $error("window_count expected %0d actual %0d", ec, cnt);
      errors++;
    end
  endfunction
endclass

module tb_windowed_mean_stddev_tracker_core;

  localparam int unsigned CycleLimit = 4000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_sample_delta;
  logic [62:0] in_sample_time;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [35:0] out_window_mean;
  logic [35:0] out_window_stddev;
  logic [7:0]  out_window_count;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  stats_scoreboard sb;
  int unsigned cycles = 0;
  int unsigned n_samples;
  int unsigned n_gaps;
  logic [62:0] clock_us;
  logic [2:0]  stall_mode;

  windowed_mean_stddev_tracker_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sample_delta(in_sample_delta), .in_sample_time(in_sample_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_window_mean(out_window_mean), .out_window_stddev(out_window_stddev),
    .out_window_count(out_window_count),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_windowed_mean_stddev_tracker_core: FAIL");
      $finish;
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_window_mean, out_window_stddev, out_window_count);
    case (stall_mode)
      3'd0: out_stall <= 1'b0;
      3'd1: out_stall <= ($urandom_range(0, 3) == 0);
      3'd2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // register write: setup then access
  task automatic write_window(logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= wmst_pkg::RegWindow;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.window_us = value;
  endtask

  // one sample beat, held until accepted
  task automatic send_sample(logic [31:0] delta, logic [62:0] t);
    in_valid <= 1'b1;
    in_sample_delta <= delta;
    in_sample_time <= t;
    do @(posedge clk); while (in_stall);
    sb.note_sample(delta, t);
    n_samples++;
  endtask

  task automatic idle_input(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // wait for every expected result, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.exp_mean.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_delta();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 | $urandom_range(0, 3);
      1: return 32'h7fff_fffc | $urandom_range(0, 3);
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 40000)) - 20000);
    endcase
  endfunction

  // advance time; occasionally jump past the window to empty the history
  function automatic logic [62:0] next_time(logic [31:0] win);
    logic [62:0] step;
    case ($urandom_range(0, 19))
      0: step = 63'(win) + 63'($urandom_range(1, 1000));
      1: step = 63'(win);
      2: step = 0;
      default: step = 63'(win / ($urandom_range(8, 200))) + 63'($urandom_range(0, 3));
    endcase
    return clock_us + step;
  endfunction

  task automatic random_phase(logic [31:0] win, int unsigned items);
    int unsigned sent;
    int unsigned burst;
    logic [62:0] t;
    sent = 0;
    while (sent < items) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < items; k++) begin
        t = next_time(win);
        if (t > clock_us + 63'(win)) n_gaps++;
        clock_us = t;
        send_sample(rand_delta(), t);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_input($urandom_range(1, 40));
      stall_mode = 3'($urandom_range(0, 3));
    end
  endtask

  initial begin
    logic [31:0] wins [5];
    sb = new();
    n_samples = 0;
    n_gaps = 0;
    stall_mode = 3'd0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_delta = '0;
    in_sample_time = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset window, extreme values, zero time, top of time range
    send_sample(32'h8000_0000, 63'd0);
    send_sample(32'h7fff_ffff, 63'd0);
    send_sample(32'h8000_0000, 63'd10);
    send_sample(32'h0000_0000, 63'd5000010);
    send_sample(32'hffff_ffff, 63'd5000011);
    // gap past the window empties the history
    send_sample(32'd7, 63'd20000000);
    // non-monotonic time counts as inside
    send_sample(32'd9, 63'd19999000);
    send_sample(32'd3, 63'd20000001);
    // the window cutoff edge: exactly now - window
    send_sample(32'd100, 63'd25000001);
    send_sample(32'd1, {1'b0, {62{1'b1}}});
    send_sample(32'h7fff_ffff, {63{1'b1}});
    send_sample(32'h5555_5555, 63'h2aaa_aaaa_aaaa_aaaa);
    send_sample(32'haaaa_aaaa, 63'h5555_5555_5555_5555);
    drain();

    // window length of one and then the largest
    write_window(32'd1);
    send_sample(32'd5, 63'd100);
    send_sample(32'd6, 63'd101);
    send_sample(32'd7, 63'd103);
    drain();
    write_window(32'hffff_ffff);
    send_sample(32'd11, 63'd200);
    send_sample(32'h8000_0000, 63'h1_0000_00c7);
    send_sample(32'd13, 63'h1_0000_00c8);
    drain();

    // random phases over several window settings
    wins[0] = 32'd5000000;
    wins[1] = 32'd1;
    wins[2] = 32'hffff_ffff;
    wins[3] = $urandom_range(100, 100000);
    wins[4] = $urandom;
    clock_us = 63'd0;
    for (int p = 0; p < 5; p++) begin
      write_window(wins[p]);
      if (p == 2) clock_us = {$urandom, $urandom} >> 2;
      random_phase(wins[p], 230);
      drain();
    end

    $display("covered %0d samples, %0d history resets by gap, %0d results checked",
             n_samples, n_gaps, sb.checked);
    $display("window lengths from 1 us to the full 32-bit range, extremes of value and time");
    if (sb.errors == 0 && sb.exp_mean.size() == 0) begin
      $display("tb_windowed_mean_stddev_tracker_core: PASS");
    end else begin
      $display("tb_windowed_mean_stddev_tracker_core: FAIL");
    end
    $finish;
  end
endmodule

// ----- files.f -----
design/wmst_pkg.sv
design/wmst_serial_div.sv
design/windowed_mean_stddev_tracker_core.sv
tb/tb_windowed_mean_stddev_tracker_core.sv
